### rtl/fgm_pkg.sv
package fgm_pkg;

   typedef logic signed [15:0] feat_type;
   typedef logic [15:0]        id_type;
   typedef logic [31:0]        order_type;

   localparam logic     CMD_MATCH  = 1'b0;
   localparam logic     CMD_UPDATE = 1'b1;

   localparam feat_type THRESH_RESET = 16'sd16384;

   // Fixed-point shifts of the similarity and renormalization math
   localparam int THR_SHIFT  = 15;
   localparam int RAD_SHIFT  = 16;
   localparam int NORM_SHIFT = 24;

   // Width of 9*old + new
   localparam int BLEND_W = 21;

   localparam logic [15:0] SAT_POS     = 16'h7FFF;
   localparam logic [15:0] SAT_NEG     = 16'h8000;
   localparam int          SAT_POS_MAG = 32767;
   localparam int          SAT_NEG_MAG = 32768;

endpackage

### rtl/fgm_ram.sv
module fgm_ram #(
   parameter int DEPTH = 2,
   parameter int AW    = 1,
   parameter int DW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fgm_isqrt.sv
module fgm_isqrt #(
   parameter int RT_W = 33
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [2*RT_W-1:0] radicand,
   output logic              done,
   output logic [RT_W-1:0]   root
);

   localparam int CNT_W = $clog2(RT_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [2*RT_W-1:0] rad_ff, rad_in;
   logic [RT_W+1:0]   rem_ff, rem_in;
   logic [RT_W-1:0]   root_ff, root_in;
   logic [RT_W+1:0]   rem_sh;
   logic [RT_W+1:0]   trial;

   assign rem_sh = {rem_ff[RT_W-1:0], rad_ff[2*RT_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(RT_W);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         // one root bit per cycle
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[RT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[RT_W-2:0], 1'b0};
         end
         rad_in = rad_ff << 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### rtl/fgm_divider.sv
module fgm_divider #(
   parameter int NUM_W = 45,
   parameter int DEN_W = 34
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W:0]   rem_sh;

   assign rem_sh = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
      end else if (busy_ff) begin
         // restoring step, quotient shifts in where the numerator leaves
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

### rtl/feature_gallery_match_update.sv
// Channel | Direction | Handshake         | Payload
// req     | in        | req_valid/stall   | command, feature, last, entry_id
// rsp     | out       | rsp_valid/stall   | found, matched_id, inserted, evicted
// csr     | in        | csr_valid/ready   | match_threshold
//
// One feature element is taken per cycle while idle; the last element starts a command.
// Match: one multiply-accumulate per cycle through the single gallery memory read port.
// Blend: each element is divided in turn by the bit-serial divider.
// Synchronous reset empties the gallery; req_stall stays high until the result is registered.
module feature_gallery_match_update #(
   parameter int FEATURE_LEN  = 128,
   parameter int GALLERY_SIZE = 50
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_command,
   input  fgm_pkg::feat_type req_feature,
   input  logic             req_last,
   input  fgm_pkg::id_type  req_entry_id,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_found,
   output fgm_pkg::id_type  rsp_matched_id,
   output logic             rsp_inserted,
   output logic             rsp_evicted,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  fgm_pkg::feat_type csr_match_threshold
);

   import fgm_pkg::*;

   localparam int LEN_W  = $clog2(FEATURE_LEN + 1);
   localparam int IX_W   = (FEATURE_LEN > 1) ? $clog2(FEATURE_LEN) : 1;
   localparam int EN_W   = (GALLERY_SIZE > 1) ? $clog2(GALLERY_SIZE) : 1;
   localparam int VDEPTH = FEATURE_LEN * GALLERY_SIZE;
   localparam int VA_W   = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
   localparam int ACC_W  = 38 + LEN_W;
   localparam int RT_W   = (ACC_W + RAD_SHIFT + 1) / 2;
   localparam int RAD_W  = 2 * RT_W;
   localparam int NUM_W  = ((RT_W > 44) ? RT_W : 44) + 1;
   localparam int DEN_W  = RT_W + 1;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MENT    = 4'd1;
   localparam logic [3:0] S_MDOT    = 4'd2;
   localparam logic [3:0] S_MDRAIN  = 4'd3;
   localparam logic [3:0] S_USCAN   = 4'd4;
   localparam logic [3:0] S_UDRAIN  = 4'd5;
   localparam logic [3:0] S_UDECIDE = 4'd6;
   localparam logic [3:0] S_COPY    = 4'd7;
   localparam logic [3:0] S_CDRAIN  = 4'd8;
   localparam logic [3:0] S_BSUM    = 4'd9;
   localparam logic [3:0] S_BDRAIN  = 4'd10;
   localparam logic [3:0] S_SQRT    = 4'd11;
   localparam logic [3:0] S_BRD     = 4'd12;
   localparam logic [3:0] S_BWAIT   = 4'd13;
   localparam logic [3:0] S_BDIV    = 4'd14;
   localparam logic [3:0] S_DONE    = 4'd15;

   logic [3:0]              state_ff, state_in;
   logic [LEN_W-1:0]        idx_ff, idx_in;
   logic [LEN_W-1:0]        qlen_ff, qlen_in;
   logic                    cmd_ff, cmd_in;
   id_type                  id_ff, id_in;
   feat_type                thr_ff;
   logic [EN_W-1:0]         ent_ff, ent_in;
   logic [IX_W-1:0]         i_ff, i_in;
   logic [VA_W-1:0]         base_ff, base_in;
   logic                    rd_v_ff, rd_v_in;
   logic [IX_W-1:0]         rd_i_ff, rd_i_in;
   logic                    prod_v_ff, prod_v_in;
   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    sq_mode_ff, sq_mode_in;
   logic [GALLERY_SIZE-1:0] valid_ff, valid_in;
   order_type               next_order_ff, next_order_in;
   logic                    have_ff, have_in;
   logic signed [ACC_W-1:0] best_ff, best_in;
   order_type               best_age_ff, best_age_in;
   id_type                  best_id_ff, best_id_in;
   logic                    sv_ff, sv_in;
   logic [EN_W-1:0]         se_ff, se_in;
   logic                    hit_ff, hit_in;
   logic [EN_W-1:0]         hit_e_ff, hit_e_in;
   logic                    free_ff, free_in;
   logic [EN_W-1:0]         free_e_ff, free_e_in;
   order_type               old_age_ff, old_age_in;
   logic [EN_W-1:0]         old_e_ff, old_e_in;
   logic [RT_W-1:0]         n_ff, n_in;
   logic                    zero_ff, zero_in;
   logic                    neg_ff, neg_in;
   logic                    res_found_ff, res_found_in;
   id_type                  res_id_ff, res_id_in;
   logic                    res_ins_ff, res_ins_in;
   logic                    res_ev_ff, res_ev_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   id_type                  rsp_id_ff, rsp_id_in;
   logic                    rsp_ins_ff, rsp_ins_in;
   logic                    rsp_ev_ff, rsp_ev_in;

   logic                    q_wr_en, q_rd_en;
   feat_type                q_rd_data;
   logic                    v_wr_en, v_rd_en;
   logic [VA_W-1:0]         v_wr_addr, v_rd_addr;
   feat_type                v_wr_data, v_rd_data;
   logic                    tab_wr_en, tab_rd_en;
   logic [EN_W-1:0]         tab_wr_addr, tab_rd_addr;
   id_type                  id_rd_data;
   order_type               ord_rd_data;
   logic                    sq_start, sq_done;
   logic [RT_W-1:0]         sq_root;
   logic                    dv_start, dv_done;
   logic [NUM_W-1:0]        dv_quot;

   feat_type                    q_pad;
   logic signed [BLEND_W-1:0]   s_calc;
   logic [BLEND_W-1:0]          s_mag;
   logic signed [2*BLEND_W-1:0] sq_prod;
   logic signed [31:0]          dot_prod;
   logic signed [ACC_W-1:0]     thr_acc;
   order_type                   age;
   logic                        upd;
   logic [EN_W-1:0]             slot;
   logic [RAD_W-1:0]            sq_rad;
   logic [NUM_W-1:0]            dv_num;
   logic [DEN_W-1:0]            dv_den;
   logic                        accept;
   logic                        last_elem;
   logic                        last_ent;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // elements past the end of a short vector read as zero
   assign q_pad   = (LEN_W'(rd_i_ff) < qlen_ff) ? q_rd_data : '0;
   assign s_calc  = (BLEND_W'(v_rd_data) <<< 3) + BLEND_W'(v_rd_data) + BLEND_W'(q_pad);
   assign s_mag   = s_calc[BLEND_W-1] ? BLEND_W'(-s_calc) : BLEND_W'(s_calc);
   assign sq_prod  = s_calc * s_calc;
   assign dot_prod = v_rd_data * q_pad;
   assign thr_acc = ACC_W'(thr_ff) <<< THR_SHIFT;
   assign age     = next_order_ff - ord_rd_data;
   assign upd     = (acc_ff > thr_acc) &&
                    (!have_ff || (acc_ff > best_ff) || ((acc_ff == best_ff) && (age > best_age_ff)));
   assign slot    = free_ff ? free_e_ff : old_e_ff;
   assign sq_rad  = RAD_W'($unsigned(acc_ff)) << RAD_SHIFT;
   assign dv_num  = (NUM_W'(s_mag) << NORM_SHIFT) + NUM_W'(n_ff);
   assign dv_den  = DEN_W'(n_ff) << 1;
   assign last_elem = (i_ff == IX_W'(FEATURE_LEN - 1));
   assign last_ent  = (ent_ff == EN_W'(GALLERY_SIZE - 1));

   assign q_rd_en     = rd_v_in;
   assign v_rd_en     = rd_v_in;
   assign v_rd_addr   = base_ff + VA_W'(i_ff);
   assign tab_rd_addr = ent_ff;
   assign tab_wr_addr = slot;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      qlen_in       = qlen_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      ent_in        = ent_ff;
      i_in          = i_ff;
      base_in       = base_ff;
      rd_v_in       = 1'b0;
      rd_i_in       = i_ff;
      prod_v_in     = rd_v_ff;
      prod_in       = sq_mode_ff ? ACC_W'(sq_prod) : ACC_W'(dot_prod);
      acc_in        = prod_v_ff ? acc_ff + prod_ff : acc_ff;
      sq_mode_in    = sq_mode_ff;
      valid_in      = valid_ff;
      next_order_in = next_order_ff;
      have_in       = have_ff;
      best_in       = best_ff;
      best_age_in   = best_age_ff;
      best_id_in    = best_id_ff;
      sv_in         = 1'b0;
      se_in         = ent_ff;
      hit_in        = hit_ff;
      hit_e_in      = hit_e_ff;
      free_in       = free_ff;
      free_e_in     = free_e_ff;
      old_age_in    = old_age_ff;
      old_e_in      = old_e_ff;
      n_in          = n_ff;
      zero_in       = zero_ff;
      neg_in        = neg_ff;
      res_found_in  = res_found_ff;
      res_id_in     = res_id_ff;
      res_ins_in    = res_ins_ff;
      res_ev_in     = res_ev_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_ins_in    = rsp_ins_ff;
      rsp_ev_in     = rsp_ev_ff;
      q_wr_en       = 1'b0;
      v_wr_en       = 1'b0;
      v_wr_addr     = base_ff + VA_W'(i_ff);
      v_wr_data     = '0;
      tab_wr_en     = 1'b0;
      tab_rd_en     = 1'b0;
      sq_start      = 1'b0;
      dv_start      = 1'b0;

      // id/age search results of the previous read
      if (sv_ff) begin
         if (valid_ff[se_ff] && (id_rd_data == id_ff) && !hit_ff) begin
            hit_in   = 1'b1;
            hit_e_in = se_ff;
         end
         if (!valid_ff[se_ff] && !free_ff) begin
            free_in   = 1'b1;
            free_e_in = se_ff;
         end
         if ((se_ff == '0) || (age > old_age_ff)) begin
            old_age_in = age;
            old_e_in   = se_ff;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (idx_ff < LEN_W'(FEATURE_LEN)) begin
                  q_wr_en = 1'b1;
                  idx_in  = idx_ff + 1'b1;
               end
               if (req_last) begin
                  qlen_in = (idx_ff < LEN_W'(FEATURE_LEN)) ? idx_ff + 1'b1 : idx_ff;
                  idx_in  = '0;
                  cmd_in  = req_command;
                  id_in   = req_entry_id;
                  ent_in  = '0;
                  base_in = '0;
                  have_in = 1'b0;
                  hit_in  = 1'b0;
                  free_in = 1'b0;
                  sq_mode_in = 1'b0;
                  state_in = (req_command == CMD_MATCH) ? S_MENT : S_USCAN;
               end
            end
         end
         S_MENT: begin
            if (valid_ff[ent_ff]) begin
               tab_rd_en = 1'b1;
               i_in      = '0;
               acc_in    = '0;
               state_in  = S_MDOT;
            end else if (last_ent) begin
               res_found_in = have_ff;
               res_id_in    = have_ff ? best_id_ff : '0;
               res_ins_in   = 1'b0;
               res_ev_in    = 1'b0;
               state_in     = S_DONE;
            end else begin
               ent_in  = ent_ff + 1'b1;
               base_in = base_ff + VA_W'(FEATURE_LEN);
            end
         end
         S_MDOT: begin
            rd_v_in = 1'b1;
            if (last_elem) begin
               state_in = S_MDRAIN;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_MDRAIN: begin
            if (!rd_v_ff && !prod_v_ff) begin
               if (upd) begin
                  have_in     = 1'b1;
                  best_in     = acc_ff;
                  best_age_in = age;
                  best_id_in  = id_rd_data;
               end
               if (last_ent) begin
                  res_found_in = have_ff || upd;
                  res_id_in    = upd ? id_rd_data : (have_ff ? best_id_ff : '0);
                  res_ins_in   = 1'b0;
                  res_ev_in    = 1'b0;
                  state_in     = S_DONE;
               end else begin
                  ent_in   = ent_ff + 1'b1;
                  base_in  = base_ff + VA_W'(FEATURE_LEN);
                  state_in = S_MENT;
               end
            end
         end
         S_USCAN: begin
            tab_rd_en = 1'b1;
            sv_in     = 1'b1;
            if (last_ent) begin
               state_in = S_UDRAIN;
            end else begin
               ent_in = ent_ff + 1'b1;
            end
         end
         S_UDRAIN: begin
            state_in = S_UDECIDE;
         end
         S_UDECIDE: begin
            i_in      = '0;
            res_id_in = id_ff;
            if (hit_ff) begin
               base_in      = VA_W'(hit_e_ff * FEATURE_LEN);
               res_found_in = 1'b1;
               res_ins_in   = 1'b0;
               res_ev_in    = 1'b0;
               sq_mode_in   = 1'b1;
               acc_in       = '0;
               state_in     = S_BSUM;
            end else begin
               tab_wr_en       = 1'b1;
               valid_in[slot]  = 1'b1;
               next_order_in   = next_order_ff + 1'b1;
               base_in         = VA_W'(slot * FEATURE_LEN);
               res_found_in    = 1'b0;
               res_ins_in      = 1'b1;
               res_ev_in       = !free_ff;
               state_in        = S_COPY;
            end
         end
         S_COPY: begin
            rd_v_in = 1'b1;
            if (last_elem) begin
               state_in = S_CDRAIN;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_CDRAIN: begin
            if (!rd_v_ff) begin
               state_in = S_DONE;
            end
         end
         S_BSUM: begin
            rd_v_in = 1'b1;
            if (last_elem) begin
               state_in = S_BDRAIN;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_BDRAIN: begin
            if (!rd_v_ff && !prod_v_ff) begin
               i_in    = '0;
               zero_in = (acc_ff == '0);
               if (acc_ff == '0) begin
                  state_in = S_BRD;
               end else begin
                  sq_start = 1'b1;
                  state_in = S_SQRT;
               end
            end
         end
         S_SQRT: begin
            if (sq_done) begin
               n_in     = sq_root;
               state_in = S_BRD;
            end
         end
         S_BRD: begin
            rd_v_in  = 1'b1;
            state_in = S_BWAIT;
         end
         S_BWAIT: begin
            neg_in = s_calc[BLEND_W-1];
            if (zero_ff) begin
               // all-zero blend stays zero
               v_wr_en = 1'b1;
               if (last_elem) begin
                  state_in = S_DONE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_BRD;
               end
            end else begin
               dv_start = 1'b1;
               state_in = S_BDIV;
            end
         end
         S_BDIV: begin
            if (dv_done) begin
               v_wr_en = 1'b1;
               if (neg_ff) begin
                  v_wr_data = (dv_quot > NUM_W'(SAT_NEG_MAG)) ? SAT_NEG : 16'(~dv_quot + 1'b1);
               end else begin
                  v_wr_data = (dv_quot > NUM_W'(SAT_POS_MAG)) ? SAT_POS : dv_quot[15:0];
               end
               if (last_elem) begin
                  state_in = S_DONE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_BRD;
               end
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_id_in    = res_id_ff;
               rsp_ins_in   = res_ins_ff;
               rsp_ev_in    = res_ev_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // copy pass writes the registered query element back in the cycle after its read
      if (((state_ff == S_COPY) || (state_ff == S_CDRAIN)) && rd_v_ff) begin
         v_wr_en   = 1'b1;
         v_wr_addr = base_ff + VA_W'(rd_i_ff);
         v_wr_data = q_pad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         qlen_ff       <= '0;
         rd_v_ff       <= 1'b0;
         prod_v_ff     <= 1'b0;
         sv_ff         <= 1'b0;
         valid_ff      <= '0;
         next_order_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         thr_ff        <= THRESH_RESET;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         qlen_ff       <= qlen_in;
         rd_v_ff       <= rd_v_in;
         prod_v_ff     <= prod_v_in;
         sv_ff         <= sv_in;
         valid_ff      <= valid_in;
         next_order_ff <= next_order_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_match_threshold;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      id_ff        <= id_in;
      ent_ff       <= ent_in;
      i_ff         <= i_in;
      base_ff      <= base_in;
      rd_i_ff      <= rd_i_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      sq_mode_ff   <= sq_mode_in;
      have_ff      <= have_in;
      best_ff      <= best_in;
      best_age_ff  <= best_age_in;
      best_id_ff   <= best_id_in;
      se_ff        <= se_in;
      hit_ff       <= hit_in;
      hit_e_ff     <= hit_e_in;
      free_ff      <= free_in;
      free_e_ff    <= free_e_in;
      old_age_ff   <= old_age_in;
      old_e_ff     <= old_e_in;
      n_ff         <= n_in;
      zero_ff      <= zero_in;
      neg_ff       <= neg_in;
      res_found_ff <= res_found_in;
      res_id_ff    <= res_id_in;
      res_ins_ff   <= res_ins_in;
      res_ev_ff    <= res_ev_in;
      rsp_found_ff <= rsp_found_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_ins_ff   <= rsp_ins_in;
      rsp_ev_ff    <= rsp_ev_in;
   end

   fgm_ram #(.DEPTH(FEATURE_LEN), .AW(IX_W), .DW(16)) u_query (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (idx_ff[IX_W-1:0]),
      .wr_data (req_feature),
      .rd_en   (q_rd_en),
      .rd_addr (i_ff),
      .rd_data (q_rd_data)
   );

   fgm_ram #(.DEPTH(VDEPTH), .AW(VA_W), .DW(16)) u_vectors (
      .clock   (clock),
      .wr_en   (v_wr_en),
      .wr_addr (v_wr_addr),
      .wr_data (v_wr_data),
      .rd_en   (v_rd_en),
      .rd_addr (v_rd_addr),
      .rd_data (v_rd_data)
   );

   fgm_ram #(.DEPTH(GALLERY_SIZE), .AW(EN_W), .DW(16)) u_ids (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (tab_wr_addr),
      .wr_data (id_ff),
      .rd_en   (tab_rd_en),
      .rd_addr (tab_rd_addr),
      .rd_data (id_rd_data)
   );

   fgm_ram #(.DEPTH(GALLERY_SIZE), .AW(EN_W), .DW(32)) u_orders (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (tab_wr_addr),
      .wr_data (next_order_ff),
      .rd_en   (tab_rd_en),
      .rd_addr (tab_rd_addr),
      .rd_data (ord_rd_data)
   );

   fgm_isqrt #(.RT_W(RT_W)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .done     (sq_done),
      .root     (sq_root)
   );

   fgm_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_divider (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .numer (dv_num),
      .denom (dv_den),
      .done  (dv_done),
      .quot  (dv_quot)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_matched_id = rsp_id_ff;
   assign rsp_inserted   = rsp_ins_ff;
   assign rsp_evicted    = rsp_ev_ff;

endmodule

### test/tb_feature_gallery_match_update.sv
module tb_feature_gallery_match_update;
   import fgm_pkg::*;

   localparam int FLEN  = 128;
   localparam int GSIZE = 50;
   localparam longint CYCLE_LIMIT = 64'd60000000;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   logic     req_command = CMD_MATCH;
   feat_type req_feature = '0;
   logic     req_last = 1'b0;
   id_type   req_entry_id = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   logic     rsp_found;
   id_type   rsp_matched_id;
   logic     rsp_inserted;
   logic     rsp_evicted;
   logic     csr_valid = 1'b0;
   logic     csr_ready;
   feat_type csr_match_threshold = '0;

   typedef struct packed {
      logic   found;
      id_type matched_id;
      logic   inserted;
      logic   evicted;
   } outcome_type;

   outcome_type outcome_q[$];

   // gallery mirror
   logic signed [31:0] query_vec [FLEN];
   feat_type           gal_vec   [GSIZE][FLEN];
   id_type             gal_id    [GSIZE];
   logic               gal_valid [GSIZE];
   order_type          gal_order [GSIZE];
   order_type          order_next;
   int                 elem_count;
   feat_type           threshold;

   int     errors = 0;
   int     results_seen = 0;
   int     matches_sent = 0;
   int     updates_sent = 0;
   longint cycles = 0;
   int     burst_left = 0;

   feature_gallery_match_update u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_feature(req_feature),
      .req_last(req_last), .req_entry_id(req_entry_id),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_found(rsp_found), .rsp_matched_id(rsp_matched_id),
      .rsp_inserted(rsp_inserted), .rsp_evicted(rsp_evicted),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_match_threshold(csr_match_threshold)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic outcome_type find_best_match();
      outcome_type o = '0;
      longint thr = longint'(threshold) * 32768;
      longint best = 0;
      longint acc;
      order_type best_age = 0;
      order_type age;
      logic have = 1'b0;
      for (int e = 0; e < GSIZE; e++) begin
         if (!gal_valid[e]) continue;
         acc = 0;
         for (int i = 0; i < FLEN; i++) acc += longint'(query_vec[i]) * longint'(gal_vec[e][i]);
         age = order_next - gal_order[e];
         if (acc > thr && (!have || acc > best || (acc == best && age > best_age))) begin
            have = 1'b1;
            best = acc;
            best_age = age;
            o.matched_id = gal_id[e];
         end
      end
      o.found = have;
      return o;
   endfunction

   task automatic blend_entry(int e);
      longint s [FLEN];
      longint unsigned total = 0;
      longint unsigned n, mag, q;
      for (int i = 0; i < FLEN; i++) begin
         s[i] = 9 * longint'(gal_vec[e][i]) + longint'(query_vec[i]);
         total += longint'(s[i] * s[i]);
      end
      if (total == 0) begin
         for (int i = 0; i < FLEN; i++) gal_vec[e][i] = '0;
         return;
      end
      n = int_sqrt(total * 65536);
      for (int i = 0; i < FLEN; i++) begin
         mag = (s[i] < 0 ? -s[i] : s[i]) * 64'd8388608;
         q = (2 * mag + n) / (2 * n);
         if (s[i] < 0) gal_vec[e][i] = (q > 32768) ? feat_type'(SAT_NEG) : feat_type'(-longint'(q));
         else gal_vec[e][i] = (q > 32767) ? feat_type'(SAT_POS) : feat_type'(q);
      end
   endtask

   task automatic update_gallery(id_type id, output outcome_type o);
      int slot = -1;
      order_type oldest = 0;
      o = '0;
      o.matched_id = id;
      for (int e = 0; e < GSIZE; e++) begin
         if (gal_valid[e] && gal_id[e] == id) begin
            blend_entry(e);
            o.found = 1'b1;
            return;
         end
      end
      for (int e = 0; e < GSIZE && slot < 0; e++) if (!gal_valid[e]) slot = e;
      if (slot < 0) begin
         for (int e = 0; e < GSIZE; e++) begin
            if (e == 0 || order_next - gal_order[e] > oldest) begin
               oldest = order_next - gal_order[e];
               slot = e;
            end
         end
         o.evicted = 1'b1;
      end
      for (int i = 0; i < FLEN; i++) gal_vec[slot][i] = feat_type'(query_vec[i]);
      gal_id[slot] = id;
      gal_valid[slot] = 1'b1;
      gal_order[slot] = order_next;
      order_next++;
      o.inserted = 1'b1;
   endtask

   task automatic predict_item(logic cmd, feat_type f, logic lst, id_type id);
      outcome_type o;
      if (elem_count < FLEN) begin
         query_vec[elem_count] = f;
         elem_count++;
      end
      if (!lst) return;
      for (int i = elem_count; i < FLEN; i++) query_vec[i] = 0;
      elem_count = 0;
      if (cmd == CMD_MATCH) begin
         o = find_best_match();
         matches_sent++;
      end else begin
         update_gallery(id, o);
         updates_sent++;
      end
      outcome_q.push_back(o);
   endtask

   // send one transaction, with a random gap between bursts
   task automatic send_item(logic cmd, feat_type f, logic lst, id_type id);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_feature  <= f;
      req_last     <= lst;
      req_entry_id <= id;
      do @(posedge clock); while (req_stall);
      predict_item(cmd, f, lst, id);
   endtask

   task automatic send_vector(logic cmd, id_type id, int len, int kind);
      feat_type f;
      for (int i = 0; i < len; i++) begin
         case (kind)
            0: f = feat_type'($urandom);
            1: f = feat_type'($urandom_range(0, 5800) - 2900);
            2: f = feat_type'(SAT_POS);
            3: f = feat_type'(SAT_NEG);
            default: f = '0;
         endcase
         send_item(cmd, f, i == len - 1, id);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      // a lone non-last element produces nothing, so give the block time to settle
      repeat (20) @(posedge clock);
   endtask

   task automatic write_threshold(feat_type v);
      drain();
      csr_valid <= 1'b1;
      csr_match_threshold <= v;
      do @(posedge clock); while (!csr_ready);
      threshold = v;
      csr_valid <= 1'b0;
   endtask

   // most items use short vectors to keep match walks cheap
   task automatic test_directed();
      send_vector(CMD_MATCH, 16'h0000, 3, 0);
      send_vector(CMD_UPDATE, 16'h0000, 1, 2);
      send_vector(CMD_UPDATE, 16'hFFFF, 2, 3);
      send_vector(CMD_UPDATE, 16'hFFFF, 2, 3);
      send_vector(CMD_UPDATE, 16'h1234, 1, 4);
      send_vector(CMD_UPDATE, 16'h1234, 2, 4);
      send_vector(CMD_MATCH, 16'h0000, 1, 2);
      send_vector(CMD_MATCH, 16'h0000, 2, 3);
      send_vector(CMD_UPDATE, 16'h0000, 2, 0);
      send_vector(CMD_MATCH, 16'hAAAA, 3, 1);
   endtask

   task automatic test_long_vectors();
      send_vector(CMD_UPDATE, 16'h0042, FLEN + 2, 1);
      send_vector(CMD_MATCH, 16'h0000, 3, 1);
   endtask

   task automatic test_thresholds();
      write_threshold(feat_type'(SAT_NEG));
      send_vector(CMD_MATCH, 16'h0000, 2, 0);
      send_vector(CMD_MATCH, 16'h0000, 1, 4);
      write_threshold(feat_type'(SAT_POS));
      send_vector(CMD_MATCH, 16'h0000, 2, 2);
      write_threshold(16'sd0);
      send_vector(CMD_MATCH, 16'h0000, 2, 1);
   endtask

   task automatic test_eviction();
      for (int k = 0; k < GSIZE + 4; k++) send_vector(CMD_UPDATE, id_type'(100 + k), 1, 1);
      send_vector(CMD_MATCH, 16'h0000, 2, 1);
   endtask

   task automatic test_random(int n_items);
      int sent = 0;
      int len;
      id_type id;
      while (sent < n_items) begin
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, FLEN) : $urandom_range(1, 4);
         id = ($urandom_range(0, 3) == 0) ? id_type'($urandom) : id_type'($urandom_range(95, 160));
         send_vector(logic'($urandom_range(0, 1)), id, len, $urandom_range(0, 4));
         sent += len;
         if ($urandom_range(0, 60) == 0) write_threshold(feat_type'($urandom));
      end
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1000 && cycles % 256 < 64) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 2) == 0);
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_feature_gallery_match_update failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      outcome_type exp_o;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (outcome_q.size() == 0) begin
            $error("result with no pending transaction");
            errors++;
         end else begin
            exp_o = outcome_q.pop_front();
            if (rsp_found !== exp_o.found) begin
               $error("found: expected %0d got %0d", exp_o.found, rsp_found);
               errors++;
            end
            if (rsp_matched_id !== exp_o.matched_id) begin
               $error("matched_id: expected %0d got %0d", exp_o.matched_id, rsp_matched_id);
               errors++;
            end
            if (rsp_inserted !== exp_o.inserted) begin
               $error("inserted: expected %0d got %0d", exp_o.inserted, rsp_inserted);
               errors++;
            end
            if (rsp_evicted !== exp_o.evicted) begin
               $error("evicted: expected %0d got %0d", exp_o.evicted, rsp_evicted);
               errors++;
            end
         end
      end
   end

   initial begin
      for (int e = 0; e < GSIZE; e++) gal_valid[e] = 1'b0;
      for (int i = 0; i < FLEN; i++) query_vec[i] = 0;
      order_next = '0;
      elem_count = 0;
      threshold = THRESH_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_long_vectors();
      test_thresholds();
      write_threshold(THRESH_RESET);
      test_eviction();
      test_random(200);
      drain();
      repeat (100) @(posedge clock);
      $display("covered %0d match and %0d update commands, %0d results checked",
               matches_sent, updates_sent, results_seen);
      if (errors == 0 && outcome_q.size() == 0) begin
         $display("tb_feature_gallery_match_update passed");
      end else begin
         $display("tb_feature_gallery_match_update failed");
      end
      $finish;
   end

endmodule
